// File: rtl/nmea_rmc_sentence_capture_defines.svh
// assertion macros for the nmea rmc capture block
`ifndef NMEA_RMC_SENTENCE_CAPTURE_DEFINES_SVH
`define NMEA_RMC_SENTENCE_CAPTURE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NRMC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define NRMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/nrmc_pkg.sv
// shared types and constants for the nmea rmc capture block
`timescale 1ns / 1ps
`default_nettype none

package nrmc_pkg;

	typedef enum logic [1:0] {
		KIND_RX      = 2'd0,
		KIND_READ    = 2'd1,
		KIND_RELEASE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_char;
		logic       read_valid;
		logic       byte_stored;
		logic       sentence_done;
	} out_item_t;

	localparam logic [2:0] HDR_LEN         = 3'd6;
	localparam logic [7:0] CHAR_DOLLAR     = 8'h24;
	localparam logic [7:0] CHAR_LF         = 8'h0a;
	localparam logic [7:0] CHAR_CR         = 8'h0d;
	localparam logic [7:0] CHAR_COMMA      = 8'd44;
	localparam logic [3:0] FIELD_LIMIT_RST = 4'd9;
	localparam logic [3:0] COMMA_MAX       = 4'd15;

	// expected "GPRMC," header
	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h47;
			3'd1: c = 8'h50;
			3'd2: c = 8'h52;
			3'd3: c = 8'h4d;
			3'd4: c = 8'h43;
			3'd5: c = 8'h2c;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/nmea_rmc_sentence_capture.sv
// nmea rmc sentence capture: header filter, comma counter and character ring buffer
// a result is registered in stage s1, then in the output register; throughput: one item per
// cycle while the output is not stalled; the character ring is a one-port-write, one-port-read
// memory with registered read data, so a pop issues its read in the transfer cycle
// reset: control state and field limit (9) clear at once, ring contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

`include "nmea_rmc_sentence_capture_defines.svh"

module nmea_rmc_sentence_capture
	import nrmc_pkg::*;
#(
	parameter int BUFFER_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_item,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_item,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data
);

	localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_DEPTH - 1);

	logic [7:0]       mem [BUFFER_DEPTH];

	logic [3:0]       field_limit_q;
	logic [2:0]       hdr_cnt_q;
	logic             hdr_ok_q;
	logic [3:0]       comma_cnt_q;
	logic             done_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;

	logic             valid_s1;
	logic             read_valid_s1;
	logic             stored_s1;
	logic             done_s1;
	logic [7:0]       rdata_s1;

	logic             out_valid_q;
	out_item_t        out_q;

	logic             accept;
	logic             adv_s1;
	logic             out_free;
	logic [7:0]       b;
	logic [IDX_W-1:0] wr_next;
	logic [IDX_W-1:0] rd_next;
	logic             empty;
	logic             rd_en;
	logic             body_byte;
	logic [3:0]       comma_new;
	logic             hit_limit;
	logic             push;

	assign cfg_ready = 1'b1;

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	assign b       = in_item.rx_byte;
	assign wr_next = (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
	assign rd_next = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
	assign empty   = (rd_idx_q == wr_idx_q);
	assign rd_en   = accept && (in_item.kind == KIND_READ) && !empty;

	// byte past a matching header, sentence open, not dollar, cr or lf
	assign body_byte = (in_item.kind == KIND_RX) && (b != CHAR_DOLLAR) &&
		(hdr_cnt_q == HDR_LEN) && hdr_ok_q && !done_q && (b != CHAR_LF) && (b != CHAR_CR);
	assign comma_new = ((b == CHAR_COMMA) && (comma_cnt_q != COMMA_MAX)) ?
		comma_cnt_q + 4'd1 : comma_cnt_q;
	assign hit_limit = (comma_new >= field_limit_q);
	assign push      = accept && body_byte && !hit_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_limit_q <= FIELD_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			field_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= '0;
			hdr_ok_q    <= 1'b0;
			comma_cnt_q <= '0;
			done_q      <= 1'b0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
		end else if (accept) begin
			case (in_item.kind)
				KIND_RX: begin
					if (b == CHAR_DOLLAR) begin
						hdr_cnt_q <= '0;
					end else if (hdr_cnt_q != HDR_LEN) begin
						hdr_ok_q  <= ((hdr_cnt_q == 3'd0) ? 1'b1 : hdr_ok_q) &&
							(b == hdr_char(hdr_cnt_q));
						hdr_cnt_q <= hdr_cnt_q + 3'd1;
					end else if (body_byte) begin
						comma_cnt_q <= comma_new;
						if (hit_limit) begin
							done_q <= 1'b1;
						end else begin
							wr_idx_q <= wr_next;
						end
					end
				end
				KIND_READ: begin
					if (!empty) begin
						rd_idx_q <= rd_next;
					end
				end
				KIND_RELEASE: begin
					done_q      <= 1'b0;
					comma_cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// character ring
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_next] <= b;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_valid_s1 <= rd_en;
			stored_s1     <= push;
			done_s1       <= (in_item.kind == KIND_RELEASE) ? 1'b0 :
				(done_q || (accept && body_byte && hit_limit));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q.read_char     <= read_valid_s1 ? rdata_s1 : 8'h00;
			out_q.read_valid    <= read_valid_s1;
			out_q.byte_stored   <= stored_s1;
			out_q.sentence_done <= done_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`NRMC_ASSERT_NOW(a_hdr_cnt_range, 1'b1, hdr_cnt_q <= HDR_LEN, "header count out of range")
	`NRMC_ASSERT_NOW(a_stall_full, in_stall, valid_s1 && out_valid_q, "stall without full pipe")
	`NRMC_ASSERT_NOW(a_read_or_store, valid_s1, !(read_valid_s1 && stored_s1), "read and store")
	`NRMC_ASSERT_NOW(a_char_zero, out_valid_q && !out_q.read_valid, out_q.read_char == 8'h00, "stray read char")
	`NRMC_ASSERT_NEXT(a_release_clears, accept && (in_item.kind == KIND_RELEASE), !done_q && (comma_cnt_q == 4'd0), "release did not clear")

endmodule

`default_nettype wire
